@@ src/cave_automaton_smoothing_pass_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cave smoothing pass
// Shared helpers for concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef CAVE_AUTOMATON_SMOOTHING_PASS_MACROS_SVH
`define CAVE_AUTOMATON_SMOOTHING_PASS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAVE_SM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CAVE_SM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cave_sm_pkg.sv @@
// ---------------------------------------------------------------------------
// cave_sm_pkg
// Types and constants shared by the cave smoothing pass modules.
// ---------------------------------------------------------------------------
package cave_sm_pkg;

    // Geometry limits and register reset values
    localparam int MAX_WIDTH_DEF        = 128;
    localparam int SIZE_MIN             = 3;
    localparam int ROW_LENGTH_RESET     = 128;
    localparam int ROW_COUNT_RESET      = 64;
    localparam int WALL_THRESHOLD_RESET = 5;

    // Register field widths
    localparam int ROW_LENGTH_W = 8;
    localparam int ROW_COUNT_W  = 12;
    localparam int THRESH_W     = 4;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;

    // Neighbors around one cell
    localparam int NEIGHBORS = 8;
    localparam int COUNT_W   = 4;

    // Tile codes
    typedef enum logic [1:0] {
        MAP_EMPTY = 2'd0,
        MAP_FLOOR = 2'd1,
        MAP_WALL  = 2'd2,
        MAP_WOOD  = 2'd3
    } tile_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_LENGTH     = 2'd0,
        CFG_ROW_COUNT      = 2'd1,
        CFG_WALL_THRESHOLD = 2'd2,
        CFG_FORCE_BORDER   = 2'd3
    } cfg_index_t;

    // Control handed to the smoothing rule
    typedef struct packed {
        logic [THRESH_W-1:0] wall_threshold;
        logic                force_border;
        logic                border;
    } rule_ctl_t;

endpackage

@@ src/cave_sm_in_if.sv @@
// ---------------------------------------------------------------------------
// cave_sm_in_if
// Tile stream channel: one tile or flush item per beat.
// ---------------------------------------------------------------------------
interface cave_sm_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] tile_in;
    logic       flush;

    modport source (output valid, output tile_in, output flush, input ready);
    modport sink   (input valid, input tile_in, input flush, output ready);

endinterface

@@ src/cave_sm_out_if.sv @@
// ---------------------------------------------------------------------------
// cave_sm_out_if
// Result channel: one smoothed tile per beat.
// ---------------------------------------------------------------------------
interface cave_sm_out_if;

    logic       valid;
    logic       ready;
    logic [1:0] tile_out;
    logic       frame_last;

    modport source (output valid, output tile_out, output frame_last, input ready);
    modport sink   (input valid, input tile_out, input frame_last, output ready);

endinterface

@@ src/cave_sm_cell.sv @@
// ---------------------------------------------------------------------------
// cave_sm_cell
// One tile of the delay chain: takes its neighbor's tile or the entry tile.
// ---------------------------------------------------------------------------
module cave_sm_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic       load_entry,
    input  logic [1:0] chain_d,
    input  logic [1:0] entry_d,
    output logic [1:0] q
);

    logic [1:0] q_reg;
    logic [1:0] q_next;

    // Pick the entry tile when this cell starts the active chain
    always_comb
    begin
        q_next = load_entry ? entry_d : chain_d;
    end

    // Advance on every shift beat
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ src/cave_sm_line.sv @@
// ---------------------------------------------------------------------------
// cave_sm_line
// One map row of delay: two fixed head cells and a tail of variable length.
// ---------------------------------------------------------------------------
module cave_sm_line #(
    parameter int MAX_WIDTH = cave_sm_pkg::MAX_WIDTH_DEF,
    parameter int TAIL_N    = MAX_WIDTH - 2,
    parameter int IDX_W     = (TAIL_N > 1) ? $clog2(TAIL_N) : 1
) (
    input  logic             clk,
    input  logic             shift,
    input  logic [IDX_W-1:0] entry,
    input  logic [1:0]       head_d,
    output logic [1:0]       tap0,
    output logic [1:0]       tap1,
    output logic [1:0]       tail_q
);

    logic [1:0] head_q [2];
    logic [1:0] cell_q [TAIL_N];

    // Head cells: always in the chain
    cave_sm_cell u_head0 (
        .clk        (clk),
        .shift      (shift),
        .load_entry (1'b0),
        .chain_d    (head_d),
        .entry_d    (head_d),
        .q          (head_q[0])
    );

    cave_sm_cell u_head1 (
        .clk        (clk),
        .shift      (shift),
        .load_entry (1'b0),
        .chain_d    (head_q[0]),
        .entry_d    (head_q[0]),
        .q          (head_q[1])
    );

    // Tail cells: the one at the entry index takes the head tile,
    // so the tail is row length minus two cells long
    genvar j;
    for (j = 0; j < TAIL_N; j++)
    begin : g_tail
        if (j == 0)
        begin : g_first
            cave_sm_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load_entry (entry == IDX_W'(j)),
                .chain_d    (head_q[1]),
                .entry_d    (head_q[1]),
                .q          (cell_q[j])
            );
        end
        else
        begin : g_rest
            cave_sm_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load_entry (entry == IDX_W'(j)),
                .chain_d    (cell_q[j-1]),
                .entry_d    (head_q[1]),
                .q          (cell_q[j])
            );
        end
    end

    assign tap0   = head_q[0];
    assign tap1   = head_q[1];
    assign tail_q = cell_q[TAIL_N-1];

endmodule

@@ src/cave_sm_rule.sv @@
// ---------------------------------------------------------------------------
// cave_sm_rule
// Smoothing rule: wall count against threshold, border pass-through or forced wall.
// ---------------------------------------------------------------------------
module cave_sm_rule (
    input  logic [cave_sm_pkg::NEIGHBORS-1:0][1:0] nbr,
    input  logic [1:0]                             center,
    input  cave_sm_pkg::rule_ctl_t                 ctl,
    output logic [1:0]                             tile
);

    import cave_sm_pkg::*;

    logic [COUNT_W-1:0] count;

    // Count wall neighbors
    always_comb
    begin
        count = '0;
        for (int k = 0; k < NEIGHBORS; k++)
        begin
            if (nbr[k] == MAP_WALL)
            begin
                count = count + COUNT_W'(1);
            end
        end
    end

    // Border keeps its tile or turns to wall; interior follows the count
    always_comb
    begin
        if (ctl.border)
        begin
            tile = ctl.force_border ? MAP_WALL : center;
        end
        else if (count >= ctl.wall_threshold)
        begin
            tile = MAP_WALL;
        end
        else
        begin
            tile = MAP_FLOOR;
        end
    end

endmodule

@@ src/cave_automaton_smoothing_pass.sv @@
// ---------------------------------------------------------------------------
// cave_automaton_smoothing_pass
// One cellular-automaton smoothing pass over a raster-order tile stream.
// ---------------------------------------------------------------------------
// The block takes one tile per clock cycle and gives at most one result per
// tile, so a full frame streams at one item per cycle with no gaps. A result
// that the sink has not taken holds the input back until the sink takes it;
// with the sink ready every cycle the input never stalls. Tiles
// move through a chain of 2*row_length+2 two-bit cells that shifts on each
// accepted tile; the 3x3 window is read from fixed taps of that chain, so a
// result appears row_length+1 tiles after its own tile. Once the last tile
// of a frame is in, send row_length+1 further items (normally flush items)
// to drain the rest; each of them shifts the chain by one and yields one
// result. A flush item sent while tiles of the frame are still expected is
// dropped. Writing row_length or row_count restarts the frame; write
// registers only while the block is idle. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "cave_automaton_smoothing_pass_macros.svh"

module cave_automaton_smoothing_pass #(
    parameter int MAX_WIDTH = cave_sm_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cave_sm_in_if.sink                         items,
    cave_sm_out_if.source                      results,
    input  logic                               wr_en,
    input  logic [cave_sm_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [cave_sm_pkg::CFG_DATA_W-1:0]  wr_data
);

    import cave_sm_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int TAIL_N  = MAX_WIDTH - 2;
    localparam int IDX_W   = (TAIL_N > 1) ? $clog2(TAIL_N) : 1;
    localparam int W_RESET = (ROW_LENGTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ROW_LENGTH_RESET;

    // Configuration; row length and row count are held as size minus one
    logic [COL_W-1:0]       wm1_reg, wm1_next;
    logic [ROW_COUNT_W-1:0] hm1_reg, hm1_next;
    logic [THRESH_W-1:0]    thr_reg, thr_next;
    logic                   force_reg, force_next;

    // Stream positions
    logic [COL_W-1:0]       in_col_reg, in_col_next;
    logic [ROW_COUNT_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic [ROW_COUNT_W-1:0] out_row_reg, out_row_next;

    // Output stage
    logic       out_valid_reg, out_valid_next;
    logic [1:0] tile_out_reg;
    logic       last_reg;

    logic                    accept;
    logic                    full;
    logic                    store;
    logic                    shift;
    logic                    emit;
    logic                    restart_cfg;
    logic [COL_W-1:0]        col_inc;
    logic [ROW_COUNT_W-1:0]  row_inc;
    logic                    primed;
    logic                    frame_end;
    logic                    pos_zero;
    logic [ROW_LENGTH_W-1:0] wr_len;
    logic [ROW_COUNT_W-1:0]  wr_cnt;
    logic [COL_W-1:0]        entry_full;
    logic [IDX_W-1:0]        entry;
    logic [1:0]              a0, a1, a_tail, b0, b1, b_tail, c0, c1;
    logic [NEIGHBORS-1:0][1:0] nbr;
    rule_ctl_t               rule_ctl;
    logic [1:0]              rule_tile;

    // Handshake: a waiting result does not stop input while the sink takes it
    assign items.ready = !out_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;
    assign full        = in_row_reg > hm1_reg;
    assign store       = accept && !full && !items.flush;
    assign shift       = store || (accept && full);

    // Input position after this tile
    always_comb
    begin
        if (in_col_reg == wm1_reg)
        begin
            col_inc = '0;
            row_inc = in_row_reg + ROW_COUNT_W'(1);
        end
        else
        begin
            col_inc = in_col_reg + COL_W'(1);
            row_inc = in_row_reg;
        end
    end

    // Result due once row_length+2 tiles of the frame are in
    assign primed    = (row_inc >= ROW_COUNT_W'(2))
                    || ((row_inc == ROW_COUNT_W'(1)) && (col_inc >= COL_W'(2)));
    assign emit      = (store && primed) || (accept && full);
    assign frame_end = (out_row_reg == hm1_reg) && (out_col_reg == wm1_reg);

    // Clamp sizes on register writes
    assign wr_len      = wr_data[ROW_LENGTH_W-1:0];
    assign wr_cnt      = wr_data[ROW_COUNT_W-1:0];
    assign restart_cfg = wr_en && ((wr_index == CFG_ROW_LENGTH) || (wr_index == CFG_ROW_COUNT));

    always_comb
    begin
        wm1_next   = wm1_reg;
        hm1_next   = hm1_reg;
        thr_next   = thr_reg;
        force_next = force_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ROW_LENGTH:
                begin
                    if (wr_len < ROW_LENGTH_W'(SIZE_MIN))
                    begin
                        wm1_next = COL_W'(SIZE_MIN - 1);
                    end
                    else if (int'(wr_len) > MAX_WIDTH)
                    begin
                        wm1_next = COL_W'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        wm1_next = COL_W'(wr_len - ROW_LENGTH_W'(1));
                    end
                end
                CFG_ROW_COUNT:
                begin
                    if (wr_cnt < ROW_COUNT_W'(SIZE_MIN))
                    begin
                        hm1_next = ROW_COUNT_W'(SIZE_MIN - 1);
                    end
                    else
                    begin
                        hm1_next = wr_cnt - ROW_COUNT_W'(1);
                    end
                end
                CFG_WALL_THRESHOLD: thr_next   = wr_data[THRESH_W-1:0];
                CFG_FORCE_BORDER:   force_next = wr_data[0];
                default:            thr_next   = thr_reg;
            endcase
        end
    end

    // Advance positions; restart on a size write or after the last cell
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart_cfg || (emit && frame_end))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (store)
            begin
                in_col_next = col_inc;
                in_row_next = row_inc;
            end
            if (emit)
            begin
                if (out_col_reg == wm1_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_COUNT_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg       <= COL_W'(W_RESET - 1);
            hm1_reg       <= ROW_COUNT_W'(ROW_COUNT_RESET - 1);
            thr_reg       <= THRESH_W'(WALL_THRESHOLD_RESET);
            force_reg     <= 1'b0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wm1_reg       <= wm1_next;
            hm1_reg       <= hm1_next;
            thr_reg       <= thr_next;
            force_reg     <= force_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            tile_out_reg <= rule_tile;
            last_reg     <= frame_end;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.tile_out   = tile_out_reg;
    assign results.frame_last = last_reg;

    // Tail entry point sets the row delay to row_length
    assign entry_full = COL_W'(MAX_WIDTH - 1) - wm1_reg;
    assign entry      = entry_full[IDX_W-1:0];

    // Cell chain: newest row, middle row, then the two oldest cells
    cave_sm_line #(
        .MAX_WIDTH (MAX_WIDTH),
        .TAIL_N    (TAIL_N),
        .IDX_W     (IDX_W)
    ) u_line_a (
        .clk    (clk),
        .shift  (shift),
        .entry  (entry),
        .head_d (items.tile_in),
        .tap0   (a0),
        .tap1   (a1),
        .tail_q (a_tail)
    );

    cave_sm_line #(
        .MAX_WIDTH (MAX_WIDTH),
        .TAIL_N    (TAIL_N),
        .IDX_W     (IDX_W)
    ) u_line_b (
        .clk    (clk),
        .shift  (shift),
        .entry  (entry),
        .head_d (a_tail),
        .tap0   (b0),
        .tap1   (b1),
        .tail_q (b_tail)
    );

    cave_sm_cell u_top0 (
        .clk        (clk),
        .shift      (shift),
        .load_entry (1'b0),
        .chain_d    (b_tail),
        .entry_d    (b_tail),
        .q          (c0)
    );

    cave_sm_cell u_top1 (
        .clk        (clk),
        .shift      (shift),
        .load_entry (1'b0),
        .chain_d    (c0),
        .entry_d    (c0),
        .q          (c1)
    );

    // Window as it stands once this beat's tile is in
    assign nbr[0] = items.tile_in;
    assign nbr[1] = a0;
    assign nbr[2] = a1;
    assign nbr[3] = a_tail;
    assign nbr[4] = b1;
    assign nbr[5] = b_tail;
    assign nbr[6] = c0;
    assign nbr[7] = c1;

    assign rule_ctl.wall_threshold = thr_reg;
    assign rule_ctl.force_border   = force_reg;
    assign rule_ctl.border         = (out_row_reg == '0) || (out_col_reg == '0)
                                  || (out_row_reg == hm1_reg) || (out_col_reg == wm1_reg);

    cave_sm_rule u_rule (
        .nbr    (nbr),
        .center (b0),
        .ctl    (rule_ctl),
        .tile   (rule_tile)
    );

    // All positions back at the frame start
    assign pos_zero = (in_row_reg == '0) && (in_col_reg == '0)
                   && (out_row_reg == '0) && (out_col_reg == '0);

    // Positions stay inside the frame
    `CAVE_SM_ASSERT_IMP(a_in_col_range, clk, rst_n, 1'b1, in_col_reg <= wm1_reg, "column past end")
    `CAVE_SM_ASSERT_IMP(a_out_row_range, clk, rst_n, 1'b1, out_row_reg <= hm1_reg, "row past end")
    // The last cell comes out only after the whole frame went in
    `CAVE_SM_ASSERT_IMP(a_last_after_full, clk, rst_n, emit && frame_end, full, "early frame end")
    // The last cell returns every position to the start
    `CAVE_SM_ASSERT_NXT(a_restart, clk, rst_n, emit && frame_end, pos_zero, "positions not cleared")

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Checks the cave smoothing pass against a predictor of its own. Tiles go
// in raster order with in-frame flushes, drain items and aborted frames;
// geometry, wall threshold and border forcing change only between frames.
// Every result beat is compared with the oldest predicted tile.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cave_sm_pkg::*;

    localparam int STORE_DEPTH   = 2 * MAX_WIDTH_DEF + 3;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 32;
    localparam int IDLE_LIMIT    = 5000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int PRINT_CAP     = 100;
    localparam int ITER_LEN      = 12;
    localparam int ITER_ROWS     = 8;
    localparam int ITER_TILES    = ITER_LEN * ITER_ROWS;

    typedef struct packed {
        tile_t tile;
        logic  last;
    } smoothed_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    cave_sm_in_if  items_if ();
    cave_sm_out_if results_if ();

    // Predictor state: registers, line store and raster positions
    logic [ROW_LENGTH_W-1:0] map_len    = ROW_LENGTH_W'(ROW_LENGTH_RESET);
    logic [ROW_COUNT_W-1:0]  map_rows   = ROW_COUNT_W'(ROW_COUNT_RESET);
    logic [THRESH_W-1:0]     map_thresh = THRESH_W'(WALL_THRESHOLD_RESET);
    logic                    map_force  = 1'b0;
    logic [1:0]              tile_mem [0:STORE_DEPTH-1];
    int unsigned             in_col, in_row, out_col, out_row;
    logic [1:0]              frame_img [0:4095];

    smoothed_t   smoothed_q [$];
    int          errors = 0;
    int unsigned work_items = 0;
    int unsigned source_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_results = 1'b0;

    cave_automaton_smoothing_pass DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items_if),
        .results  (results_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned map_width();
        int unsigned w;
        w = map_len;
        if (w < SIZE_MIN)
            w = SIZE_MIN;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int unsigned map_height();
        int unsigned h;
        h = map_rows;
        if (h < SIZE_MIN)
            h = SIZE_MIN;
        return h;
    endfunction

    function automatic int unsigned store_slot(input int unsigned r, input int unsigned c,
                                               input int unsigned w);
        return (r * w + c) % STORE_DEPTH;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the map by one accepted beat and queue the tile it releases
    function automatic void smooth_step(input logic [1:0] tile, input logic is_flush);
        int unsigned w, h, r, c, walls;
        int          dr, dc;
        smoothed_t   res;
        w = map_width();
        h = map_height();
        if (in_row < h)
        begin
            if (is_flush)
                return;
            tile_mem[store_slot(in_row, in_col, w)] = tile;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (in_row * w + in_col < w + 2)
                return;
        end
        r = out_row;
        c = out_col;
        if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w)
        begin
            res.tile = map_force ? MAP_WALL : tile_t'(tile_mem[store_slot(r, c, w)]);
        end
        else
        begin
            walls = 0;
            for (dr = -1; dr <= 1; dr++)
                for (dc = -1; dc <= 1; dc++)
                    if ((dr != 0 || dc != 0) &&
                        tile_mem[store_slot(r + dr, c + dc, w)] == MAP_WALL)
                        walls++;
            res.tile = (walls >= map_thresh) ? MAP_WALL : MAP_FLOOR;
        end
        res.last = (r + 1 == h && c + 1 == w);
        if (r * w + c < 4096)
            frame_img[r * w + c] = res.tile;
        smoothed_q.push_back(res);
        if (res.last)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    task automatic report(input string msg);
        if (errors < PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Predict on tile beats, check on result beats
    always @(posedge clk)
    begin
        smoothed_t want;
        if (rst_n)
        begin
            if (items_if.valid === 1'b1 && items_if.ready === 1'b1)
                smooth_step(items_if.tile_in, items_if.flush);
            if (results_if.valid === 1'b1 && results_if.ready === 1'b1)
            begin
                if (smoothed_q.size() == 0)
                    report($sformatf("result beat with no tile pending (tile_out=%0d)",
                                     results_if.tile_out));
                else
                begin
                    want = smoothed_q.pop_front();
                    if (results_if.tile_out !== want.tile)
                        report($sformatf("tile_out %0d, predicted %0d",
                                         results_if.tile_out, want.tile));
                    if (results_if.frame_last !== want.last)
                        report($sformatf("frame_last %0d, predicted %0d",
                                         results_if.frame_last, want.last));
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request
    always
    begin
        @(posedge clk);
        if (!rst_n)
            results_if.ready <= 1'b0;
        else if (hold_results)
        begin
            results_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_results = 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            results_if.ready <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
        else
            results_if.ready <= 1'b1;
    end

    // Stop the run when no beat moves for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((items_if.valid === 1'b1 && items_if.ready === 1'b1) ||
                (results_if.valid === 1'b1 && results_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL cave_automaton_smoothing_pass");
        $finish;
    end

    task automatic send_item(input logic [1:0] tile, input logic is_flush);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < source_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.valid   <= 1'b1;
        items_if.tile_in <= tile;
        items_if.flush   <= is_flush;
        do
            @(posedge clk);
        while (items_if.ready !== 1'b1);
    endtask

    // Drop valid and hold until every predicted tile has come out
    task automatic wait_results();
        items_if.valid <= 1'b0;
        @(posedge clk);
        while (smoothed_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_ROW_LENGTH:
            begin
                map_len = value[ROW_LENGTH_W-1:0];
                restart_frame();
            end
            CFG_ROW_COUNT:
            begin
                map_rows = value[ROW_COUNT_W-1:0];
                restart_frame();
            end
            CFG_WALL_THRESHOLD: map_thresh = value[THRESH_W-1:0];
            CFG_FORCE_BORDER:   map_force = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned len, input int unsigned rows);
        write_reg(CFG_ROW_LENGTH, len);
        write_reg(CFG_ROW_COUNT, rows);
    endtask

    function automatic logic [1:0] random_tile(input int unsigned wall_pct);
        if ($urandom_range(0, 99) < wall_pct)
            return MAP_WALL;
        case ($urandom_range(0, 2))
            0:       return MAP_EMPTY;
            1:       return MAP_FLOOR;
            default: return MAP_WOOD;
        endcase
    endfunction

    // Raster tiles with the odd flush mixed in, which the block drops
    task automatic send_tiles(input int unsigned count, input int unsigned wall_pct);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 4)
                send_item(random_tile(50), 1'b1);
            send_item(random_tile(wall_pct), 1'b0);
            work_items++;
        end
    endtask

    // Push out the last row plus one tile; some drain beats carry plain tiles
    task automatic drain_frame(input int unsigned plain_pct);
        repeat (map_width() + 1)
        begin
            send_item(random_tile(50), ($urandom_range(0, 99) < plain_pct) ? 1'b0 : 1'b1);
            work_items++;
        end
    endtask

    task automatic test_directed_frames();
        tile_t ring [9]  = '{MAP_WALL, MAP_WALL, MAP_WALL,
                             MAP_WALL, MAP_FLOOR, MAP_WALL,
                             MAP_WALL, MAP_WALL, MAP_WALL};
        tile_t mixed [9] = '{MAP_EMPTY, MAP_WOOD, MAP_FLOOR,
                             MAP_WOOD, MAP_EMPTY, MAP_FLOOR,
                             MAP_EMPTY, MAP_WOOD, MAP_FLOOR};
        int i;
        source_gap_pct = 0;
        sink_stall_pct = 0;
        set_geometry(3, 3);
        write_reg(CFG_WALL_THRESHOLD, 8);
        write_reg(CFG_FORCE_BORDER, 0);
        // all eight neighbors are wall; a flush inside the frame is dropped
        for (i = 0; i < 9; i++)
        begin
            send_item(ring[i], 1'b0);
            if (i == 3)
                send_item(MAP_WALL, 1'b1);
        end
        send_item(MAP_WOOD, 1'b0);
        repeat (3) send_item(MAP_EMPTY, 1'b1);
        // no walls at all, zero threshold, forced border
        wait_idle();
        write_reg(CFG_WALL_THRESHOLD, 0);
        write_reg(CFG_FORCE_BORDER, 1);
        for (i = 0; i < 9; i++)
            send_item(mixed[i], 1'b0);
        send_item(MAP_FLOOR, 1'b0);
        repeat (3) send_item(MAP_WOOD, 1'b1);
    endtask

    task automatic test_size_clamp();
        source_gap_pct = 20;
        sink_stall_pct = 20;
        // below the minimum size on both axes
        wait_idle();
        set_geometry(0, 2);
        write_reg(CFG_WALL_THRESHOLD, 15);
        write_reg(CFG_FORCE_BORDER, 0);
        send_tiles(9, 70);
        drain_frame(50);
        // row length above the maximum
        wait_idle();
        set_geometry(255, 0);
        write_reg(CFG_WALL_THRESHOLD, 0);
        write_reg(CFG_FORCE_BORDER, 1);
        send_tiles(384, 40);
        drain_frame(0);
        // widest and tallest frame, cut short by the next size write
        wait_idle();
        set_geometry(128, 4095);
        write_reg(CFG_WALL_THRESHOLD, 3);
        write_reg(CFG_FORCE_BORDER, 0);
        send_tiles(128 + 20, 50);
    endtask

    task automatic test_backpressure();
        wait_idle();
        set_geometry(10, 6);
        write_reg(CFG_WALL_THRESHOLD, 4);
        write_reg(CFG_FORCE_BORDER, 0);
        source_gap_pct = 0;
        sink_stall_pct = 0;
        // hold the result side while tiles keep coming
        hold_results = 1'b1;
        send_tiles(60, 50);
        drain_frame(0);
        // pause mid-frame until the block has emptied
        send_tiles(30, 50);
        wait_results();
        send_tiles(30, 50);
        drain_frame(0);
    endtask

    task automatic test_iterations();
        logic [1:0] pass_map [0:ITER_TILES-1];
        int         i, k;
        wait_idle();
        set_geometry(ITER_LEN, ITER_ROWS);
        write_reg(CFG_WALL_THRESHOLD, 5);
        write_reg(CFG_FORCE_BORDER, 0);
        source_gap_pct = 20;
        sink_stall_pct = 20;
        send_tiles(ITER_TILES, 45);
        drain_frame(10);
        // feed each smoothed map back in as the next pass
        for (k = 0; k < 2; k++)
        begin
            if (k == 1)
            begin
                wait_idle();
                write_reg(CFG_FORCE_BORDER, 1);
            end
            else
                wait_results();
            for (i = 0; i < ITER_TILES; i++)
                pass_map[i] = frame_img[i];
            for (i = 0; i < ITER_TILES; i++)
            begin
                send_item(pass_map[i], 1'b0);
                work_items++;
            end
            drain_frame(10);
        end
    endtask

    task automatic test_random_frames();
        int unsigned goal, len_raw, rows_raw, w, h, pick;
        bit          restart_due;
        goal = work_items + RANDOM_ITEMS;
        restart_due = 1'b1;
        while (work_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                len_raw  = $urandom_range(3, 12);
                rows_raw = $urandom_range(3, 10);
            end
            else if (pick < 90)
            begin
                len_raw  = $urandom_range(13, 48);
                rows_raw = $urandom_range(3, 6);
            end
            else if (pick < 95)
            begin
                len_raw  = $urandom_range(100, 255);
                rows_raw = 3;
            end
            else
            begin
                len_raw  = $urandom_range(0, 2);
                rows_raw = $urandom_range(0, 2);
            end
            if (restart_due || $urandom_range(0, 99) < 40)
            begin
                wait_idle();
                set_geometry(len_raw, rows_raw);
                write_reg(CFG_WALL_THRESHOLD, ($urandom_range(0, 99) < 80) ?
                          $urandom_range(0, 8) : $urandom_range(9, 15));
                write_reg(CFG_FORCE_BORDER, $urandom_range(0, 1));
                restart_due = 1'b0;
            end
            if ($urandom_range(0, 99) < 30)
            begin
                source_gap_pct = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                source_gap_pct = $urandom_range(5, 50);
                sink_stall_pct = $urandom_range(5, 50);
            end
            w = map_width();
            h = map_height();
            // now and then abandon a frame; the next size write restarts it
            if ($urandom_range(0, 99) < 8)
            begin
                send_tiles($urandom_range(1, w * h - 1), $urandom_range(10, 90));
                restart_due = 1'b1;
            end
            else
            begin
                send_tiles(w * h, $urandom_range(10, 90));
                drain_frame(20);
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = CFG_ROW_LENGTH;
        wr_data          = '0;
        items_if.valid   = 1'b0;
        items_if.tile_in = MAP_EMPTY;
        items_if.flush   = 1'b0;
        results_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_size_clamp();
        test_backpressure();
        test_iterations();
        test_random_frames();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS cave_automaton_smoothing_pass");
        else
            $display("FAIL cave_automaton_smoothing_pass");
        $finish;
    end

endmodule
